@@ hdl/head_axis_output_conditioner_unit_macros.svh @@
// assertion helpers for the conditioner rtl
`ifndef HEAD_AXIS_OUTPUT_CONDITIONER_UNIT_MACROS_SVH
`define HEAD_AXIS_OUTPUT_CONDITIONER_UNIT_MACROS_SVH

// same-cycle implication
`define HAOC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HAOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/haoc_pkg.sv @@
`default_nettype none

package haoc_pkg;

   // field widths
   localparam int ANGLE_WIDTH  = 15;
   localparam int DIFF_WIDTH   = 17;
   localparam int GAIN_WIDTH   = 13;
   localparam int BETA_WIDTH   = 7;
   localparam int PULSE_WIDTH  = 12;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 13;

   // register reset values
   localparam int GAIN_RESET   = 256;
   localparam int CENTER_RESET = 1500;
   localparam int MIN_RESET    = 988;
   localparam int MAX_RESET    = 2012;

   // angle wrap, 1/64 degree
   localparam int WRAP_HALF    = 11520;
   localparam int WRAP_FULL    = 23040;

   localparam int PERCENT_FULL = 100;

   // filter state width, holds +-2^21 in 1/64 us
   localparam int SV_WIDTH     = 22;
   localparam int SV_BIAS      = 1 << (SV_WIDTH - 1);
   // bias keeps the dividend positive so the reciprocal product floors
   localparam int DIV_BIAS     = PERCENT_FULL * SV_BIAS + PERCENT_FULL / 2;
   localparam int RECIP_SHIFT  = 36;
   localparam logic [29:0] RECIP_MUL =
      30'((64'd1 << RECIP_SHIFT) / PERCENT_FULL + 64'd1);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_AXIS_GAIN     = 3'd0,
      CSR_AXIS_REVERSED = 3'd1,
      CSR_SMOOTHING     = 3'd2,
      CSR_CENTER_PULSE  = 3'd3,
      CSR_MIN_PULSE     = 3'd4,
      CSR_MAX_PULSE     = 3'd5,
      CSR_WRAP_MODE     = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

@@ hdl/haoc_if.sv @@
`default_nettype none

interface haoc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [haoc_pkg::ANGLE_WIDTH-1:0] angle;
   logic                                    zero_now;

   modport source (output valid, output angle, output zero_now, input ready);
   modport sink   (input valid, input angle, input zero_now, output ready);
endinterface

interface haoc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [haoc_pkg::PULSE_WIDTH-1:0] pulse_width;

   modport source (output valid, output pulse_width, input ready);
   modport sink   (input valid, input pulse_width, output ready);
endinterface

interface haoc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [haoc_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [haoc_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/head_axis_output_conditioner_unit.sv @@
// channel   dir   payload                        accepted when
// req_bus   in    angle[15] s, zero_now[1]       valid & ready
// rsp_bus   out   pulse_width[12]                valid & ready
// csr_bus   in    index[3], data[13]             valid & ready (always ready)
//
// under 8 states a sample is taken only in idle, steps through scale, mix1, mix2,
// sum, div, store, out before the next is taken; one shared 31x31 multiplier is
// used four times (gain, two filter weights, divide by 100 through a reciprocal).
// the result sits in an output register; a stalled rsp holds the sequencer
// in its last state until the beat leaves.
// synchronous reset restores register defaults and clears offset and filter.
`default_nettype none

`include "head_axis_output_conditioner_unit_macros.svh"

module head_axis_output_conditioner_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   haoc_req_if.sink    req_bus,
   haoc_rsp_if.source  rsp_bus,
   haoc_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCALE, S_MIX1, S_MIX2, S_SUM, S_DIV, S_STORE, S_OUT
   } state_type;

   localparam int DW = haoc_pkg::DIFF_WIDTH;
   localparam int SW = haoc_pkg::SV_WIDTH;
   localparam int PW = haoc_pkg::PULSE_WIDTH;

   state_type state_ff, state_in;

   logic [haoc_pkg::GAIN_WIDTH-1:0] gain_ff, gain_in;
   logic                            reversed_ff, reversed_in;
   logic [haoc_pkg::BETA_WIDTH-1:0] smooth_ff, smooth_in;
   logic [PW-1:0]                   center_ff, center_in;
   logic [PW-1:0]                   min_ff, min_in;
   logic [PW-1:0]                   max_ff, max_in;
   logic                            wrap_ff, wrap_in;

   logic signed [haoc_pkg::ANGLE_WIDTH-1:0] zero_offset_ff, zero_offset_in;
   logic signed [SW-1:0]                    sv_ff, sv_in;

   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [SW-1:0] scaled_ff, scaled_in;
   logic signed [27:0]   acc_ff, acc_in;
   logic [28:0]          x_ff, x_in;
   logic signed [61:0]   mul_p_ff, mul_p_in;
   logic signed [30:0]   mul_a, mul_b;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] pulse_ff, pulse_in;

   logic                                    req_fire;
   logic signed [haoc_pkg::ANGLE_WIDTH-1:0] zero_eff;
   logic signed [DW-1:0]                    diff_raw;
   logic signed [17:0]                      shifted, wrapped;
   logic [haoc_pkg::BETA_WIDTH-1:0]         beta;
   logic signed [30:0]                      rnd_scaled;
   logic signed [SW-1:0]                    scaled_mag;
   logic signed [29:0]                      x_sum;
   logic [SW-1:0]                           quot;
   logic signed [SW:0]                      rnd_sv;
   logic signed [17:0]                      pulse_s, max_s, min_s, pulse_hi;
   logic                                    out_go;

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pulse_width = pulse_ff;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_go   = !rsp_valid_ff || rsp_bus.ready;

   // angle relative to zero, optionally folded into one turn
   always_comb begin
      zero_eff = req_bus.zero_now ? req_bus.angle : zero_offset_ff;
      diff_raw = DW'(req_bus.angle) - DW'(zero_eff);
      shifted  = 18'(diff_raw) + 18'(haoc_pkg::WRAP_HALF);
      if (shifted < 18'sd0) begin
         wrapped = shifted + 18'(haoc_pkg::WRAP_FULL);
      end else if (shifted >= 18'(haoc_pkg::WRAP_FULL)) begin
         wrapped = shifted - 18'(haoc_pkg::WRAP_FULL);
      end else begin
         wrapped = shifted;
      end
      wrapped = wrapped - 18'(haoc_pkg::WRAP_HALF);
   end

   assign beta = (smooth_ff > haoc_pkg::BETA_WIDTH'(haoc_pkg::PERCENT_FULL)) ?
                 haoc_pkg::BETA_WIDTH'(haoc_pkg::PERCENT_FULL) : smooth_ff;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_SCALE: begin
            mul_a = 31'(diff_ff);
            mul_b = signed'(31'(gain_ff));
         end
         S_MIX1: begin
            mul_a = 31'(sv_ff);
            mul_b = signed'(31'(beta));
         end
         S_MIX2: begin
            mul_a = 31'(scaled_ff);
            mul_b = signed'(31'(haoc_pkg::BETA_WIDTH'(haoc_pkg::PERCENT_FULL) - beta));
         end
         S_DIV: begin
            mul_a = signed'(31'(x_ff));
            mul_b = signed'(31'(haoc_pkg::RECIP_MUL));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p_in = 62'(mul_a) * 62'(mul_b);
   end

   always_comb begin
      // round half up, drop 8 fraction bits of the gain
      rnd_scaled = 31'(signed'(mul_p_ff[29:0])) + 31'sd128;
      scaled_mag = SW'(rnd_scaled >>> 8);
      x_sum      = 30'(acc_ff) + 30'(signed'(mul_p_ff[27:0])) + 30'(haoc_pkg::DIV_BIAS);
      quot       = mul_p_ff[haoc_pkg::RECIP_SHIFT+SW-1:haoc_pkg::RECIP_SHIFT];
      rnd_sv     = (SW+1)'(sv_ff) + (SW+1)'(32);
      pulse_s    = 18'(rnd_sv >>> 6) + signed'(18'(center_ff));
      max_s      = signed'(18'(max_ff));
      min_s      = signed'(18'(min_ff));
      pulse_hi   = (pulse_s > max_s) ? max_s : pulse_s;
      if (pulse_hi < min_s) begin
         pulse_hi = min_s;
      end
   end

   always_comb begin
      state_in       = state_ff;
      gain_in        = gain_ff;
      reversed_in    = reversed_ff;
      smooth_in      = smooth_ff;
      center_in      = center_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      wrap_in        = wrap_ff;
      zero_offset_in = zero_offset_ff;
      sv_in          = sv_ff;
      diff_in        = diff_ff;
      scaled_in      = scaled_ff;
      acc_in         = acc_ff;
      x_in           = x_ff;
      pulse_in       = pulse_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      if (csr_bus.valid) begin
         case (haoc_pkg::csr_index_type'(csr_bus.index))
            haoc_pkg::CSR_AXIS_GAIN:     gain_in     = csr_bus.data[haoc_pkg::GAIN_WIDTH-1:0];
            haoc_pkg::CSR_AXIS_REVERSED: reversed_in = csr_bus.data[0];
            haoc_pkg::CSR_SMOOTHING:     smooth_in   = csr_bus.data[haoc_pkg::BETA_WIDTH-1:0];
            haoc_pkg::CSR_CENTER_PULSE:  center_in   = csr_bus.data[PW-1:0];
            haoc_pkg::CSR_MIN_PULSE:     min_in      = csr_bus.data[PW-1:0];
            haoc_pkg::CSR_MAX_PULSE:     max_in      = csr_bus.data[PW-1:0];
            haoc_pkg::CSR_WRAP_MODE:     wrap_in     = csr_bus.data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               zero_offset_in = zero_eff;
               diff_in        = wrap_ff ? DW'(wrapped) : diff_raw;
               state_in       = S_SCALE;
            end
         end
         S_SCALE: state_in = S_MIX1;
         S_MIX1: begin
            scaled_in = reversed_ff ? -scaled_mag : scaled_mag;
            state_in  = S_MIX2;
         end
         S_MIX2: begin
            acc_in   = signed'(mul_p_ff[27:0]);
            state_in = S_SUM;
         end
         S_SUM: begin
            x_in     = x_sum[28:0];
            state_in = S_DIV;
         end
         S_DIV: state_in = S_STORE;
         S_STORE: begin
            sv_in    = signed'(quot - SW'(haoc_pkg::SV_BIAS));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_go) begin
               pulse_in     = pulse_hi[PW-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff  <= mul_p_in;
      diff_ff   <= diff_in;
      scaled_ff <= scaled_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      pulse_ff  <= pulse_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         gain_ff        <= haoc_pkg::GAIN_WIDTH'(haoc_pkg::GAIN_RESET);
         reversed_ff    <= 1'b0;
         smooth_ff      <= '0;
         center_ff      <= PW'(haoc_pkg::CENTER_RESET);
         min_ff         <= PW'(haoc_pkg::MIN_RESET);
         max_ff         <= PW'(haoc_pkg::MAX_RESET);
         wrap_ff        <= 1'b0;
         zero_offset_ff <= '0;
         sv_ff          <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         gain_ff        <= gain_in;
         reversed_ff    <= reversed_in;
         smooth_ff      <= smooth_in;
         center_ff      <= center_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         wrap_ff        <= wrap_in;
         zero_offset_ff <= zero_offset_in;
         sv_ff          <= sv_in;
      end
   end

   `HAOC_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == S_SCALE,
      "accepted beat did not start the sequencer")
   `HAOC_ASSERT_NEXT(a_out_loads, clock, reset, (state_ff == S_OUT) && out_go,
      rsp_valid_ff && (state_ff == S_IDLE), "result not presented after last step")
   `HAOC_ASSERT_NOW(a_valid_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_OUT), "result appeared outside the output step")
   `HAOC_ASSERT_NEXT(a_zero_capture, clock, reset, req_fire && req_bus.zero_now,
      zero_offset_ff == $past(req_bus.angle), "zero offset not captured")

endmodule

`default_nettype wire
